FILE: sv/rstoi_pkg.sv
package rstoi_pkg;

   localparam int MaxDigits  = 16;
   localparam int AlphaChars = 16;
   localparam int CharWidth  = 8;
   localparam int LenWidth   = 5;
   localparam int DigitWidth = 4;
   localparam int ValueWidth = 32;
   localparam int CsrDataWidth  = 64;
   localparam int CsrIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] CsrAlphaLow  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrAlphaHigh = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrAlphaLen  = 2'd2;

   localparam logic [CharWidth-1:0] CharNul   = 8'd0;
   localparam logic [CharWidth-1:0] CharTab   = 8'd9;
   localparam logic [CharWidth-1:0] CharCr    = 8'd13;
   localparam logic [CharWidth-1:0] CharSpace = 8'd32;
   localparam logic [CharWidth-1:0] CharPlus  = 8'd43;
   localparam logic [CharWidth-1:0] CharMinus = 8'd45;

   localparam logic [1:0] PhaseSpace = 2'd0;
   localparam logic [1:0] PhaseSign  = 2'd1;
   localparam logic [1:0] PhaseDigit = 2'd2;
   localparam logic [1:0] PhaseDone  = 2'd3;

   typedef logic [CharWidth-1:0] char_type;

   typedef struct packed {
      logic [AlphaChars-1:0][CharWidth-1:0] chars;
      logic [LenWidth-1:0]                  length;
   } alphabet_type;

   typedef struct packed {
      logic                  ok;
      logic                  hit;
      logic [DigitWidth-1:0] digit;
   } lookup_type;

   function automatic logic is_space(input char_type c);
      return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
   endfunction

endpackage

FILE: sv/rstoi_csr.sv
module rstoi_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [rstoi_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [rstoi_pkg::CsrDataWidth-1:0]      csr_data,
   output rstoi_pkg::alphabet_type                 alphabet
);
   import rstoi_pkg::*;

   logic [CsrDataWidth-1:0] alpha_low_ff, alpha_low_in;
   logic [CsrDataWidth-1:0] alpha_high_ff, alpha_high_in;
   logic [LenWidth-1:0]     alpha_len_ff, alpha_len_in;

   assign csr_ready = 1'b1;

   always_comb begin
      alpha_low_in  = alpha_low_ff;
      alpha_high_in = alpha_high_ff;
      alpha_len_in  = alpha_len_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CsrAlphaLow:  alpha_low_in  = csr_data;
            CsrAlphaHigh: alpha_high_in = csr_data;
            CsrAlphaLen:  alpha_len_in  = csr_data[LenWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_low_ff  <= '0;
         alpha_high_ff <= '0;
         alpha_len_ff  <= '0;
      end else begin
         alpha_low_ff  <= alpha_low_in;
         alpha_high_ff <= alpha_high_in;
         alpha_len_ff  <= alpha_len_in;
      end
   end

   always_comb begin
      for (int k = 0; k < AlphaChars / 2; k++) begin
         alphabet.chars[k] = alpha_low_ff[CharWidth*k +: CharWidth];
         alphabet.chars[k + AlphaChars / 2] = alpha_high_ff[CharWidth*k +: CharWidth];
      end
      alphabet.length = alpha_len_ff;
   end

endmodule

FILE: sv/rstoi_lookup.sv
module rstoi_lookup (
   input  rstoi_pkg::alphabet_type alphabet,
   input  rstoi_pkg::char_type     text_byte,
   output rstoi_pkg::lookup_type   lookup
);
   import rstoi_pkg::*;

   logic [LenWidth-1:0] limit;

   // digit match, lowest position wins
   assign limit = (alphabet.length > LenWidth'(AlphaChars)) ?
                  LenWidth'(AlphaChars) : alphabet.length;

   // alphabet check: length range, forbidden characters, pairwise duplicates; then the digit match
   always_comb begin
      lookup.ok = (alphabet.length >= LenWidth'(2)) &&
                  (alphabet.length <= LenWidth'(MaxDigits));
      for (int i = 0; i < AlphaChars; i++) begin
         if (LenWidth'(i) < alphabet.length) begin
            if ((alphabet.chars[i] == CharNul) || is_space(alphabet.chars[i]) ||
                (alphabet.chars[i] == CharPlus) || (alphabet.chars[i] == CharMinus)) begin
               lookup.ok = 1'b0;
            end
            for (int j = i + 1; j < AlphaChars; j++) begin
               if ((LenWidth'(j) < alphabet.length) &&
                   (alphabet.chars[j] == alphabet.chars[i])) begin
                  lookup.ok = 1'b0;
               end
            end
         end
      end

      lookup.hit   = 1'b0;
      lookup.digit = '0;
      for (int k = AlphaChars - 1; k >= 0; k--) begin
         if ((LenWidth'(k) < limit) && (alphabet.chars[k] == text_byte)) begin
            lookup.hit   = 1'b1;
            lookup.digit = DigitWidth'(k);
         end
      end
   end

endmodule

FILE: sv/rstoi_parse.sv
module rstoi_parse (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 take,
   input  rstoi_pkg::char_type                  text_byte,
   input  rstoi_pkg::lookup_type                lookup,
   input  logic [rstoi_pkg::LenWidth-1:0]       radix,
   output logic                                 emit,
   output logic [rstoi_pkg::ValueWidth-1:0]     value,
   output logic                                 alphabet_valid
);
   import rstoi_pkg::*;

   logic [1:0]            phase_ff, phase_in;
   logic                  negative_ff, negative_in;
   logic [ValueWidth-1:0] acc_ff, acc_in;
   logic [ValueWidth-1:0] product;
   logic [ValueWidth-1:0] acc_digit;
   logic [1:0]            phase_digit;

   assign product = acc_ff * ValueWidth'(radix);

   always_comb begin
      acc_digit   = acc_ff;
      phase_digit = PhaseDone;
      if (lookup.hit) begin
         acc_digit   = product + ValueWidth'(lookup.digit);
         phase_digit = PhaseDigit;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      negative_in = negative_ff;
      acc_in      = acc_ff;
      if (take) begin
         if (text_byte == CharNul) begin
            phase_in    = PhaseSpace;
            negative_in = 1'b0;
            acc_in      = '0;
         end else begin
            unique case (phase_ff)
               PhaseSpace, PhaseSign: begin
                  if ((phase_ff == PhaseSpace) && is_space(text_byte)) begin
                     phase_in = PhaseSpace;
                  end else if (text_byte == CharMinus) begin
                     negative_in = ~negative_ff;
                     phase_in    = PhaseSign;
                  end else if (text_byte == CharPlus) begin
                     phase_in = PhaseSign;
                  end else begin
                     acc_in   = acc_digit;
                     phase_in = phase_digit;
                  end
               end
               PhaseDigit: begin
                  acc_in   = acc_digit;
                  phase_in = phase_digit;
               end
               PhaseDone: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PhaseSpace;
         negative_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         phase_ff    <= phase_in;
         negative_ff <= negative_in;
         acc_ff      <= acc_in;
      end
   end

   assign emit           = take && (text_byte == CharNul);
   assign alphabet_valid = lookup.ok;
   assign value          = !lookup.ok ? '0 : (negative_ff ? ('0 - acc_ff) : acc_ff);

endmodule

FILE: sv/radix_string_to_integer_unit.sv
// Radix string to integer unit.
// req channel: one text byte per transaction on req_tdata; a zero byte ends
// the string. rsp channel: one transaction per string, carrying the signed
// 32-bit value on rsp_tdata and the alphabet check flag on rsp_tuser (value
// is zero when the alphabet is rejected). csr channel: index 0 and 1 load
// digit characters 0-7 and 8-15, index 2 the alphabet length (radix).
// Throughput: one byte per cycle while no zero byte waits on rsp. Each byte
// passes an input register, a combinational lookup and a 32x5 multiply-add
// feeding the accumulator, which is the loop that sets the one-byte-per-cycle
// rate. A zero byte passes the input register, then the result register to rsp.
// Reset clears the configuration to zero, the parser state and the valid flags
// of both registers. While rsp is stalled, non-zero bytes keep flowing; a zero
// byte waits in the input register until the pending result is taken, and req
// backs up behind it.
module radix_string_to_integer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [7:0] text_byte
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [31:0]                          rsp_tdata,  // [31:0] value
   output logic                                 rsp_tuser,  // [0] alphabet_valid
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rstoi_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [rstoi_pkg::CsrDataWidth-1:0]   csr_data
);
   import rstoi_pkg::*;

   alphabet_type          alphabet;
   lookup_type            lookup;
   logic                  in_valid_ff, in_valid_in;
   char_type              in_byte_ff, in_byte_in;
   logic                  take;
   logic                  emit;
   logic [ValueWidth-1:0] value;
   logic                  alpha_ok;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ValueWidth-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_ok_ff, rsp_ok_in;

   rstoi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .alphabet  (alphabet)
   );

   rstoi_lookup u_lookup (
      .alphabet  (alphabet),
      .text_byte (in_byte_ff),
      .lookup    (lookup)
   );

   rstoi_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .text_byte      (in_byte_ff),
      .lookup         (lookup),
      .radix          (alphabet.length),
      .emit           (emit),
      .value          (value),
      .alphabet_valid (alpha_ok)
   );

   assign take = in_valid_ff &&
                 ((in_byte_ff != CharNul) || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || take;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = value;
         rsp_ok_in    = alpha_ok;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff   <= in_byte_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_ok_ff;

`ifndef SYNTH
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("rejected alphabet with nonzero value");

   a_rsp_from_nul: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(in_valid_ff && (in_byte_ff == CharNul)))
      else $error("result without terminating byte");

   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && in_valid_ff) |-> take)
      else $error("input register overwritten before use");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (emit && rsp_valid_ff) |-> rsp_tready)
      else $error("result register overrun");
`endif

endmodule

FILE: tb/sv/radix_string_to_integer_unit_tb.sv
module radix_string_to_integer_unit_tb;
   import rstoi_pkg::*;

   localparam int ResetCycles = 7;
   localparam int DrainCycles = 10;
   localparam int HoldCycles  = 300;
   localparam int CycleLimit  = 400000;
   localparam int RandomBytes = 1550;
   localparam int CalmBytes   = 200;
   localparam int ReportLimit = 10;

   typedef struct packed {
      logic [ValueWidth-1:0] value;
      logic                  alpha_ok;
   } parse_result_type;

   typedef enum int {
      FlawNone,
      FlawShort,
      FlawLong,
      FlawDuplicate,
      FlawBadChar
   } alphabet_flaw_type;

   class radix_parse_scoreboard;
      char_type              digit_chars [AlphaChars];
      logic [LenWidth-1:0]   radix;
      logic [1:0]            phase;
      logic                  negative;
      logic [ValueWidth-1:0] acc;
      parse_result_type      results_due [$];
      int                    faults;

      function new();
         foreach (digit_chars[k]) digit_chars[k] = '0;
         radix    = '0;
         phase    = PhaseSpace;
         negative = 1'b0;
         acc      = '0;
         faults   = 0;
      endfunction

      function bit blank(char_type c);
         return c == CharSpace || (c >= CharTab && c <= CharCr);
      endfunction

      function void load_register(logic [CsrIndexWidth-1:0] index,
                                  logic [CsrDataWidth-1:0] data);
         case (index)
            CsrAlphaLow: begin
               for (int k = 0; k < 8; k++) digit_chars[k] = data[8*k +: 8];
            end
            CsrAlphaHigh: begin
               for (int k = 0; k < 8; k++) digit_chars[k+8] = data[8*k +: 8];
            end
            CsrAlphaLen: begin
               radix = data[LenWidth-1:0];
            end
            default: ;
         endcase
      endfunction

      // lowest matching position wins; only the first radix characters count
      function void take_digit(char_type c);
         int hit;
         hit = -1;
         for (int k = AlphaChars - 1; k >= 0; k--)
            if (k < radix && digit_chars[k] == c) hit = k;
         if (hit >= 0) begin
            acc   = acc * ValueWidth'(radix) + ValueWidth'(hit);
            phase = PhaseDigit;
         end else begin
            phase = PhaseDone;
         end
      endfunction

      function void take_byte(char_type c);
         bit               ok;
         int               n;
         parse_result_type due;
         if (c == CharNul) begin
            n  = radix;
            ok = n >= 2 && n <= MaxDigits;
            for (int i = 0; i < n && ok; i++) begin
               if (digit_chars[i] == CharNul || blank(digit_chars[i]) ||
                   digit_chars[i] == CharPlus || digit_chars[i] == CharMinus)
                  ok = 1'b0;
               for (int j = i + 1; j < n; j++)
                  if (digit_chars[j] == digit_chars[i]) ok = 1'b0;
            end
            due.alpha_ok = ok;
            due.value    = !ok ? '0 : negative ? -acc : acc;
            results_due.push_back(due);
            phase    = PhaseSpace;
            negative = 1'b0;
            acc      = '0;
         end else begin
            if (phase == PhaseSpace && !blank(c)) phase = PhaseSign;
            case (phase)
               PhaseSign: begin
                  if (c == CharMinus) negative = ~negative;
                  else if (c != CharPlus) take_digit(c);
               end
               PhaseDigit: begin
                  take_digit(c);
               end
               default: ;
            endcase
         end
      endfunction

      function void check_result(logic [ValueWidth-1:0] value, logic flag);
         parse_result_type due;
         if (results_due.size() == 0) begin
            faults++;
            if (faults <= ReportLimit)
               $display("unexpected result: value %0d, alphabet flag %0b",
                        $signed(value), flag);
            return;
         end
         due = results_due.pop_front();
         if (value !== due.value || flag !== due.alpha_ok) begin
            faults++;
            if (faults <= ReportLimit)
               $display("result mismatch: value %0d (expected %0d), flag %0b (expected %0b)",
                        $signed(value), $signed(due.value), flag, due.alpha_ok);
         end
      endfunction

      function int pending();
         return results_due.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [7:0]               req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [31:0]              rsp_tdata;
   logic                     rsp_tuser;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_data;

   radix_parse_scoreboard    parser_model;
   logic [AlphaChars*CharWidth-1:0] alpha_bits;
   logic [LenWidth-1:0]      alpha_len;
   int                       req_idle_pct;
   int                       rsp_idle_pct;
   bit                       calm;
   bit                       hold_rsp;
   int                       sent_bytes;
   int                       cycle_count = 0;

   radix_string_to_integer_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAIL radix_string_to_integer_unit");
         $finish;
      end
   end

   // results are checked before this edge's input transaction is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) parser_model.check_result(rsp_tdata, rsp_tuser);
         if (csr_valid && csr_ready) parser_model.load_register(csr_index, csr_data);
         if (req_tvalid && req_tready) parser_model.take_byte(req_tdata);
      end
   end

   initial begin
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 10)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_byte(char_type c);
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      sent_bytes++;
      if (!calm && $urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic send_text(char_type text [$]);
      foreach (text[i]) send_byte(text[i]);
   endtask

   // wait out all pending results plus the pipeline of non-terminating bytes
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (parser_model.pending() != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic load_alphabet(logic [AlphaChars*CharWidth-1:0] bits,
                                logic [LenWidth-1:0] len);
      logic [CsrIndexWidth-1:0] slot [3];
      logic [CsrDataWidth-1:0]  word [3];
      slot[0] = CsrAlphaLow;
      slot[1] = CsrAlphaHigh;
      slot[2] = CsrAlphaLen;
      word[0] = bits[63:0];
      word[1] = bits[127:64];
      word[2] = CsrDataWidth'(len);
      alpha_bits = bits;
      alpha_len  = len;
      csr_valid <= 1'b1;
      for (int i = 0; i < 3; i++) begin
         csr_index <= slot[i];
         csr_data  <= word[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [AlphaChars*CharWidth-1:0] alphabet_from(string digits);
      logic [AlphaChars*CharWidth-1:0] bits;
      bits = '0;
      for (int k = 0; k < digits.len(); k++) bits[8*k +: 8] = digits[k];
      return bits;
   endfunction

   function automatic void make_alphabet(alphabet_flaw_type flaw,
                                         output logic [AlphaChars*CharWidth-1:0] bits,
                                         output logic [LenWidth-1:0] len);
      bit [255:0] taken;
      char_type   c;
      int         a;
      int         b;
      bits  = {$urandom, $urandom, $urandom, $urandom};
      taken = '0;
      case (flaw)
         FlawShort: len = LenWidth'($urandom_range(0, 1));
         FlawLong:  len = $urandom_range(0, 1) ? 5'd31 : LenWidth'($urandom_range(17, 31));
         default: begin
            if ($urandom_range(0, 3) == 0) len = 5'd16;
            else if ($urandom_range(0, 3) == 0) len = 5'd2;
            else len = LenWidth'($urandom_range(2, 16));
         end
      endcase
      for (int k = 0; k < AlphaChars; k++)
         if (k < len) begin
            do c = CharWidth'($urandom_range(1, 255));
            while (taken[c] || c == CharPlus || c == CharMinus || c == CharSpace ||
                   (c >= CharTab && c <= CharCr));
            taken[c] = 1'b1;
            bits[8*k +: 8] = c;
         end
      if (flaw == FlawDuplicate) begin
         a = $urandom_range(1, len - 1);
         b = $urandom_range(0, a - 1);
         bits[8*a +: 8] = bits[8*b +: 8];
      end else if (flaw == FlawBadChar) begin
         a = $urandom_range(0, len - 1);
         case ($urandom_range(0, 4))
            0:       c = CharNul;
            1:       c = CharPlus;
            2:       c = CharMinus;
            3:       c = CharSpace;
            default: c = CharWidth'($urandom_range(CharTab, CharCr));
         endcase
         bits[8*a +: 8] = c;
      end
   endfunction

   // mostly well-formed numbers; some noise and some with no digits after the blanks and signs
   task automatic send_random_string(bit terminate);
      char_type text [$];
      int       shape;
      int       n;
      int       k;
      shape = $urandom_range(0, 99);
      if (shape < 15) begin
         repeat ($urandom_range(0, 8)) text.push_back(CharWidth'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 3))
            text.push_back($urandom_range(0, 5) == 0 ? CharSpace :
                           CharWidth'($urandom_range(CharTab, CharCr)));
         repeat ($urandom_range(0, 3))
            text.push_back($urandom_range(0, 1) ? CharPlus : CharMinus);
         n = shape < 25 ? 0 : $urandom_range(1, 12);
         repeat (n) begin
            k = $urandom_range(0, (alpha_len >= 2 && alpha_len <= 16) ? alpha_len - 1 : 15);
            text.push_back(alpha_bits[8*k +: 8]);
         end
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) text.push_back(CharWidth'($urandom_range(1, 255)));
      end
      if (terminate) text.push_back(CharNul);
      send_text(text);
   endtask

   initial begin
      char_type                        text [$];
      logic [AlphaChars*CharWidth-1:0] bits;
      logic [LenWidth-1:0]             len;
      int                              phase_no;
      int                              phase_end;
      parser_model = new();
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = CsrAlphaLow;
      csr_data     = '0;
      calm         = 1'b0;
      hold_rsp     = 1'b0;
      req_idle_pct = 20;
      rsp_idle_pct = 10;
      sent_bytes   = 0;
      alpha_bits   = '0;
      alpha_len    = '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // empty string under the reset alphabet
      send_byte(CharNul);
      settle();

      load_alphabet(alphabet_from("0123456789"), 5'd10);
      text = '{CharTab, CharCr, CharSpace, CharMinus, CharPlus, CharMinus,
               "4", "2", "a", "7", CharNul};
      send_text(text);
      settle();

      // full 16-character alphabet with a top-bit character, then wraparound
      bits = alphabet_from("0123456789abcde");
      bits[127:120] = 8'hFF;
      load_alphabet(bits, 5'd16);
      text = '{CharMinus};
      repeat (8) text.push_back(8'hFF);
      text.push_back("1");
      text.push_back(CharNul);
      text.push_back("7");
      text.push_back("f");
      text.push_back(CharNul);
      send_text(text);

      phase_no = 0;
      while (sent_bytes < RandomBytes) begin
         settle();
         if (phase_no == 0) begin
            bits = alphabet_from("01");
            len  = 5'd2;
         end else if (phase_no < 6) begin
            make_alphabet(alphabet_flaw_type'(phase_no - 1), bits, len);
         end else begin
            make_alphabet($urandom_range(0, 3) != 0 ? FlawNone :
                          alphabet_flaw_type'($urandom_range(1, 4)), bits, len);
         end
         load_alphabet(bits, len);
         req_idle_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(5, 40);
         rsp_idle_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(2, 15);
         hold_rsp     = phase_no == 1 || $urandom_range(0, 9) == 0;
         phase_end    = sent_bytes + $urandom_range(40, 120);
         while (sent_bytes < phase_end) send_random_string(1'b1);
         // leave a string open across the next register change
         if ($urandom_range(0, 2) == 0) send_random_string(1'b0);
         phase_no++;
      end

      settle();
      calm = 1'b1;
      make_alphabet(FlawNone, bits, len);
      load_alphabet(bits, len);
      phase_end = sent_bytes + CalmBytes;
      while (sent_bytes < phase_end) send_random_string(1'b1);
      settle();

      if (parser_model.faults == 0 && parser_model.pending() == 0)
         $display("PASS radix_string_to_integer_unit");
      else
         $display("FAIL radix_string_to_integer_unit");
      $finish;
   end

endmodule

FILE: radix_string_to_integer_unit.f
sv/rstoi_pkg.sv
sv/rstoi_csr.sv
sv/rstoi_lookup.sv
sv/rstoi_parse.sv
sv/radix_string_to_integer_unit.sv
tb/sv/radix_string_to_integer_unit_tb.sv
